/* design/swpe_pkg.sv */
// ============================================================================
// swpe_pkg
// Shared types and constants for the sliding-window peak event counter.
// ============================================================================
package swpe_pkg;

    // timestamp field widths
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int TIME_W  = 17;   // seconds of day
    localparam int COUNT_W = 9;    // reported counts

    localparam int unsigned DAY_SECONDS   = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 17'd180;

    // constant reciprocals for splitting seconds of day into h:m:s
    localparam int                HOUR_RECIP_W = 18;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = 18'd149131;  // ceil(2^29 / 3600)
    localparam int                HOUR_SHIFT   = 29;
    localparam int                MIN_RECIP_W  = 13;
    localparam logic [MIN_RECIP_W-1:0]  MIN_RECIP  = 13'd4370;    // ceil(2^18 / 60)
    localparam int                MIN_SHIFT    = 18;
    localparam int                REM_W        = 12;              // seconds within an hour

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // one classified event moving between the parts
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] tod;
    } time_beat_t;

endpackage

/* design/swpe_front.sv */
// ============================================================================
// swpe_front
// Accepts event timestamps and turns them into wrapped seconds of day.
// ============================================================================
module swpe_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [swpe_pkg::HOUR_W-1:0] event_hour,
    input  logic [swpe_pkg::MIN_W-1:0]  event_minute,
    input  logic [swpe_pkg::SEC_W-1:0]  event_second,
    input  logic                       queue_full,
    output swpe_pkg::time_beat_t       push_beat
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [swpe_pkg::TIME_W-1:0] tod_reg;
    logic [swpe_pkg::TIME_W-1:0] tod_raw;
    logic [swpe_pkg::TIME_W-1:0] tod_wrapped;
    logic                        accept;
    logic                        push;

    // h*3600 + m*60 + s, then one wrap into the day
    always_comb
    begin
        tod_raw = swpe_pkg::TIME_W'(event_hour) * swpe_pkg::TIME_W'(swpe_pkg::SECS_PER_HOUR)
                + swpe_pkg::TIME_W'(event_minute) * swpe_pkg::TIME_W'(swpe_pkg::SECS_PER_MIN)
                + swpe_pkg::TIME_W'(event_second);
        if (tod_raw >= swpe_pkg::TIME_W'(swpe_pkg::DAY_SECONDS))
        begin
            tod_wrapped = tod_raw - swpe_pkg::TIME_W'(swpe_pkg::DAY_SECONDS);
        end
        else
        begin
            tod_wrapped = tod_raw;
        end
    end

    assign push     = valid_reg && !queue_full;
    assign in_stall = valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tod_reg <= tod_wrapped;
        end
    end

    assign push_beat.valid = push;
    assign push_beat.tod   = tod_reg;

endmodule

/* design/swpe_queue.sv */
// ============================================================================
// swpe_queue
// Short queue of classified events between the front and the back.
// ============================================================================
module swpe_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  swpe_pkg::time_beat_t push_beat,
    output logic                 full,
    input  logic                 pop,
    output swpe_pkg::time_beat_t head_beat
);

    logic [swpe_pkg::TIME_W-1:0]      entry_reg [swpe_pkg::QUEUE_DEPTH];
    logic [swpe_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [swpe_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [swpe_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full    = count_reg == swpe_pkg::QUEUE_CNT_W'(swpe_pkg::QUEUE_DEPTH);
    assign do_push = push_beat.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head_beat.valid = count_reg != '0;
    assign head_beat.tod   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == swpe_pkg::QUEUE_PTR_W'(swpe_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == swpe_pkg::QUEUE_PTR_W'(swpe_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_beat.tod;
        end
    end

endmodule

/* design/swpe_back.sv */
// ============================================================================
// swpe_back
// Expires old events from the event memory, pushes the new one, tracks the
// peak window and drives the result register.
// ============================================================================
module swpe_back
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [swpe_pkg::TIME_W-1:0]  window,
    input  swpe_pkg::time_beat_t         head_beat,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [swpe_pkg::COUNT_W-1:0] window_count,
    output logic [swpe_pkg::COUNT_W-1:0] best_count,
    output logic [swpe_pkg::HOUR_W-1:0]  best_start_hour,
    output logic [swpe_pkg::MIN_W-1:0]   best_start_minute,
    output logic [swpe_pkg::SEC_W-1:0]   best_start_second,
    output logic                         overflow
);

    localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int TW      = swpe_pkg::TIME_W;
    localparam int PROD1_W = swpe_pkg::TIME_W + swpe_pkg::HOUR_RECIP_W;
    localparam int PROD2_W = swpe_pkg::REM_W + swpe_pkg::MIN_RECIP_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DEC1  = 3'd2;
    localparam logic [2:0] ST_DEC2  = 3'd3;
    localparam logic [2:0] ST_DEC3  = 3'd4;
    localparam logic [2:0] ST_DEC4  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // event memory
    logic [TW-1:0]    mem [FIFO_DEPTH];
    logic [TW-1:0]    rd_data_reg;
    logic             mem_we;

    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [TW-1:0]    peak_start_reg, peak_start_next;
    logic [TW-1:0]    now_reg, now_next;
    logic             ovf_reg, ovf_next;

    logic [swpe_pkg::HOUR_W-1:0] hour_reg, hour_next;
    logic [swpe_pkg::MIN_W-1:0]  minute_reg, minute_next;
    logic [swpe_pkg::SEC_W-1:0]  second_reg, second_next;
    logic [PROD1_W-1:0]          prod1_reg, prod1_next;
    logic [PROD2_W-1:0]          prod2_reg, prod2_next;
    logic [swpe_pkg::REM_W-1:0]  rem_reg, rem_next;

    logic                         out_valid_reg, out_valid_next;
    logic [swpe_pkg::COUNT_W-1:0] window_count_reg, window_count_next;
    logic [swpe_pkg::COUNT_W-1:0] best_count_reg, best_count_next;
    logic [swpe_pkg::HOUR_W-1:0]  best_hour_reg, best_hour_next;
    logic [swpe_pkg::MIN_W-1:0]   best_minute_reg, best_minute_next;
    logic [swpe_pkg::SEC_W-1:0]   best_second_reg, best_second_next;
    logic                         overflow_reg, overflow_next;

    logic [TW:0]          diff;
    logic                 expire;
    logic                 full;
    logic [CNT_W-1:0]     count_after;
    logic                 out_free;
    logic [PTR_W-1:0]     head_inc;
    logic [PTR_W-1:0]     tail_inc;

    assign out_free = !out_valid_reg || !out_stall;
    assign head_inc = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign full     = count_reg == CNT_W'(FIFO_DEPTH);

    // wrapped age of the oldest stored event
    always_comb
    begin
        if (now_reg >= rd_data_reg)
        begin
            diff = {1'b0, now_reg} - {1'b0, rd_data_reg};
        end
        else
        begin
            diff = {1'b0, now_reg} + (TW + 1)'(swpe_pkg::DAY_SECONDS) - {1'b0, rd_data_reg};
        end
    end

    assign expire      = (count_reg != '0) && (diff > {1'b0, window});
    assign count_after = full ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        peak_next         = peak_reg;
        peak_start_next   = peak_start_reg;
        now_next          = now_reg;
        ovf_next          = ovf_reg;
        hour_next         = hour_reg;
        minute_next       = minute_reg;
        second_next       = second_reg;
        prod1_next        = prod1_reg;
        prod2_next        = prod2_reg;
        rem_next          = rem_reg;
        mem_we            = 1'b0;
        pop               = 1'b0;
        out_valid_next    = out_valid_reg && out_stall;
        window_count_next = window_count_reg;
        best_count_next   = best_count_reg;
        best_hour_next    = best_hour_reg;
        best_minute_next  = best_minute_reg;
        best_second_next  = best_second_reg;
        overflow_next     = overflow_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_beat.valid)
                begin
                    pop        = 1'b1;
                    now_next   = head_beat.tod;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (expire)
                begin
                    // drop one stale event; the next head arrives next cycle
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    tail_next  = tail_inc;
                    count_next = count_after;
                    ovf_next   = full;
                    if (full)
                    begin
                        head_next = head_inc;
                    end
                    if (count_after > peak_reg)
                    begin
                        peak_next       = count_after;
                        peak_start_next = (count_reg == '0) ? now_reg : rd_data_reg;
                        state_next      = ST_DEC1;
                    end
                    else if (out_free)
                    begin
                        out_valid_next    = 1'b1;
                        window_count_next = swpe_pkg::COUNT_W'(count_after);
                        best_count_next   = swpe_pkg::COUNT_W'(peak_reg);
                        best_hour_next    = hour_reg;
                        best_minute_next  = minute_reg;
                        best_second_next  = second_reg;
                        overflow_next     = full;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DEC1:
            begin
                prod1_next = PROD1_W'(peak_start_reg) * PROD1_W'(swpe_pkg::HOUR_RECIP);
                state_next = ST_DEC2;
            end
            ST_DEC2:
            begin
                hour_next  = swpe_pkg::HOUR_W'(prod1_reg >> swpe_pkg::HOUR_SHIFT);
                rem_next   = swpe_pkg::REM_W'(peak_start_reg
                           - TW'(swpe_pkg::HOUR_W'(prod1_reg >> swpe_pkg::HOUR_SHIFT))
                           * TW'(swpe_pkg::SECS_PER_HOUR));
                state_next = ST_DEC3;
            end
            ST_DEC3:
            begin
                prod2_next = PROD2_W'(rem_reg) * PROD2_W'(swpe_pkg::MIN_RECIP);
                state_next = ST_DEC4;
            end
            ST_DEC4:
            begin
                minute_next = swpe_pkg::MIN_W'(prod2_reg >> swpe_pkg::MIN_SHIFT);
                second_next = swpe_pkg::SEC_W'(rem_reg
                            - swpe_pkg::REM_W'(swpe_pkg::MIN_W'(prod2_reg >> swpe_pkg::MIN_SHIFT))
                            * swpe_pkg::REM_W'(swpe_pkg::SECS_PER_MIN));
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    window_count_next = swpe_pkg::COUNT_W'(count_reg);
                    best_count_next   = swpe_pkg::COUNT_W'(peak_reg);
                    best_hour_next    = hour_reg;
                    best_minute_next  = minute_reg;
                    best_second_next  = second_reg;
                    overflow_next     = ovf_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory: read the head that will be current next cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= now_reg;
        end
        rd_data_reg <= mem[head_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            peak_reg       <= '0;
            peak_start_reg <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            peak_reg       <= peak_next;
            peak_start_reg <= peak_start_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg          <= now_next;
        ovf_reg          <= ovf_next;
        prod1_reg        <= prod1_next;
        prod2_reg        <= prod2_next;
        rem_reg          <= rem_next;
        window_count_reg <= window_count_next;
        best_count_reg   <= best_count_next;
        best_hour_reg    <= best_hour_next;
        best_minute_reg  <= best_minute_next;
        best_second_reg  <= best_second_next;
        overflow_reg     <= overflow_next;
    end

    assign out_valid         = out_valid_reg;
    assign window_count      = window_count_reg;
    assign best_count        = best_count_reg;
    assign best_start_hour   = best_hour_reg;
    assign best_start_minute = best_minute_reg;
    assign best_start_second = best_second_reg;
    assign overflow          = overflow_reg;

endmodule

/* design/sliding_window_peak_event_count.sv */
// ============================================================================
// sliding_window_peak_event_count
// Counts events inside a sliding time window and tracks the peak window.
// ============================================================================
// Usage:
//   Input beats carry one event timestamp (hour, minute, second) in time
//   order; an input beat moves when in_valid is high and in_stall is low.
//   Each input beat yields exactly one output beat with the current window
//   count, the best count so far, the start time of the best window and an
//   overflow flag; it moves when out_valid is high and out_stall is low.
//   cfg_we writes the window length in seconds (reset 180); write it only
//   while no event is in flight.
// Flow:
//   A front stage converts the timestamp into a two-entry queue. The back
//   part pops an event in IDLE and checks it in CHECK, which expires one
//   stale event per pass (one read of the event memory per cycle) and then
//   stores the event; when a new peak is set, the start time is split into
//   h:m:s by two reciprocal multiplies in states DEC1 to DEC4 before EMIT.
// Reset and stall:
//   Reset empties the event store and clears the peak to 0 at 0:0:0.
//   A stalled result is held; the queue fills and then in_stall rises.
// ============================================================================
module sliding_window_peak_event_count
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [swpe_pkg::TIME_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [swpe_pkg::HOUR_W-1:0]  event_hour,
    input  logic [swpe_pkg::MIN_W-1:0]   event_minute,
    input  logic [swpe_pkg::SEC_W-1:0]   event_second,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [swpe_pkg::COUNT_W-1:0] window_count,
    output logic [swpe_pkg::COUNT_W-1:0] best_count,
    output logic [swpe_pkg::HOUR_W-1:0]  best_start_hour,
    output logic [swpe_pkg::MIN_W-1:0]   best_start_minute,
    output logic [swpe_pkg::SEC_W-1:0]   best_start_second,
    output logic                         overflow
);

    logic [swpe_pkg::TIME_W-1:0] window_reg;
    swpe_pkg::time_beat_t        push_beat;
    swpe_pkg::time_beat_t        head_beat;
    logic                        queue_full;
    logic                        queue_pop;

    // window length register; hold between writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= swpe_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_data;
        end
    end

    // front: accept and convert timestamps
    swpe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .event_hour   (event_hour),
        .event_minute (event_minute),
        .event_second (event_second),
        .queue_full   (queue_full),
        .push_beat    (push_beat)
    );

    // queue: decouple front stalls from back work
    swpe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_beat (push_beat),
        .full      (queue_full),
        .pop       (queue_pop),
        .head_beat (head_beat)
    );

    // back: expire, push, track peak, drive results
    swpe_back
    #(
        .FIFO_DEPTH (FIFO_DEPTH)
    )
    u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .window            (window_reg),
        .head_beat         (head_beat),
        .pop               (queue_pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .window_count      (window_count),
        .best_count        (best_count),
        .best_start_hour   (best_start_hour),
        .best_start_minute (best_start_minute),
        .best_start_second (best_start_second),
        .overflow          (overflow)
    );

endmodule
